FILE: rtl/afps_pkg.sv
// constants, coefficient tables and rounding helpers shared by the power spectrum block
package afps_pkg;

  localparam int FFT_N      = 64;
  localparam int LOG_N      = $clog2(FFT_N);
  localparam int STG_W      = $clog2(LOG_N);
  localparam int WIN_D      = FFT_N - 1;
  localparam int SMP_W      = 16;
  localparam int IN_DATA_W  = 2 * SMP_W;
  localparam int DB_W       = 16;
  localparam int OUT_DATA_W = ((LOG_N + DB_W + 7) / 8) * 8;
  localparam int COEF_W     = 17;
  localparam int XW         = SMP_W + 10;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 48;
  localparam int CNT_W      = 9;
  localparam int FD_W       = 8;
  localparam int DIV_W      = ACC_W + 8;
  localparam int NORM_W     = 64;
  localparam int M_W        = 31;
  localparam int FRAC_W     = 24;
  localparam int LG_W       = FRAC_W + 7;
  localparam int PW_SH      = 2 * (SMP_W - 1) + 2 * LOG_N - 39;
  localparam int MAX_AVG    = 256;
  localparam int DB_MIN     = -30720;

  localparam logic signed [MUL_W-1:0] DB_K    = 33'sd50504453;
  localparam logic [NORM_W-1:0]       EPS_Q47 = 64'd141;

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint CDEN [6]    = '{132, 90, 56, 30, 12, 2};
  localparam longint SDEN [6]    = '{156, 110, 72, 42, 20, 6};

  typedef logic signed [COEF_W-1:0] coef_tab_t [FFT_N];

  // round half away from zero, elaboration-time version
  function automatic longint rnd_l(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  // q30 cosine or sine of 2*pi*p/d, d is the window span or the fft size
  function automatic longint trig_q30(int p, bit use_win, bit want_sin);
    longint q, quad, r, x, x2, tc, ts, cv, sv, c, s;
    int k;
    if (use_win) begin
      q    = 4 * (longint'(p) % WIN_D);
      quad = q / WIN_D;
      r    = q % WIN_D;
      x    = (r * HALF_PI_Q30) / WIN_D;
    end else begin
      q    = 4 * (longint'(p) % FFT_N);
      quad = q / FFT_N;
      r    = q % FFT_N;
      x    = (r * HALF_PI_Q30) / FFT_N;
    end
    x2 = (x * x) >>> 30;
    tc = Q30_ONE;
    ts = Q30_ONE;
    for (k = 0; k < 5; k++) tc = Q30_ONE - ((x2 * tc) >>> 30) / CDEN[k];
    cv = Q30_ONE - ((x2 * tc) >>> 30) / CDEN[5];
    for (k = 0; k < 6; k++) ts = Q30_ONE - ((x2 * ts) >>> 30) / SDEN[k];
    sv = (x * ts) >>> 30;
    case (quad & 3)
      0: begin c = cv;  s = sv;  end
      1: begin c = -sv; s = cv;  end
      2: begin c = -cv; s = -sv; end
      default: begin c = sv; s = -cv; end
    endcase
    return want_sin ? s : c;
  endfunction

  function automatic coef_tab_t build_win();
    coef_tab_t t;
    for (int n = 0; n < FFT_N; n++) t[n] = COEF_W'(rnd_l(Q30_ONE - trig_q30(n, 1'b1, 1'b0), 16));
    return t;
  endfunction

  function automatic coef_tab_t build_tw(bit want_sin);
    coef_tab_t t;
    for (int n = 0; n < FFT_N; n++) t[n] = COEF_W'(rnd_l(trig_q30(n, 1'b0, want_sin), 15));
    return t;
  endfunction

  localparam coef_tab_t WIN_TAB = build_win();
  localparam coef_tab_t TW_COS  = build_tw(1'b0);
  localparam coef_tab_t TW_SIN  = build_tw(1'b1);

  // round half away from zero on a product word
  function automatic logic signed [PROD_W-1:0] rnd_sh(logic signed [PROD_W-1:0] v, int s);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) << (s - 1);
    if (v[PROD_W-1]) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic logic [LOG_N-1:0] bit_rev(logic [LOG_N-1:0] v);
    logic [LOG_N-1:0] r;
    for (int i = 0; i < LOG_N; i++) r[i] = v[LOG_N-1-i];
    return r;
  endfunction

endpackage

FILE: rtl/afps_mul.sv
// shared signed multiplier with registered product
module afps_mul (
  input  logic                                   clk_i,
  input  logic signed [afps_pkg::MUL_W-1:0]      a_i,
  input  logic signed [afps_pkg::MUL_W-1:0]      b_i,
  output logic signed [afps_pkg::PROD_W-1:0]     p_o
);
  import afps_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/afps_div.sv
// restoring divider, one quotient bit per cycle
module afps_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [afps_pkg::DIV_W-1:0]      dividend_i,
  input  logic [afps_pkg::CNT_W-1:0]      divisor_i,
  output logic                            done_o,
  output logic [afps_pkg::DIV_W-1:0]      quotient_o
);
  import afps_pkg::*;

  localparam int DC_W = $clog2(DIV_W);

  logic            busy_q, done_q;
  logic [DC_W-1:0] cnt_q;
  logic [DIV_W-1:0] quo_q;
  logic [CNT_W-1:0] rem_q, dsr_q;
  logic [CNT_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DC_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/averaged_fft_power_spectrum.sv
// averaged hann-windowed fft power spectrum in db, top level
//
// Complex I/Q samples enter one word at a time. Each sample is windowed on
// arrival and stored in bit-reversed order: the word is accepted, passes the
// multiplier for I and then Q, and is written before the next word is taken. The
// 64th word of a frame starts a radix-2 fft: 192 butterflies, each a read, four
// products through the one shared 33x33 multiplier, then two writes to the
// single-write work memory, followed by a pass that adds each bin power into its
// accumulator. Every frames_to_average frames (0 acts as 1, above 256 as 256)
// the block emits 64 words, DC centred; each bin takes a serial divide for the
// mean, one-bit normalizing shifts, 24 squarings for the log2 fraction and a
// final scaling product. Input is not taken while a frame or a spectrum is
// being worked on. A finished word sits in an output register, so the next bin
// is computed while it waits. Accumulator clearing is immediate through per-bin
// valid bits; no clearing pass.
module averaged_fft_power_spectrum (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [afps_pkg::CNT_W-1:0]           cfg_wdata_i,     // frames_to_average
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [afps_pkg::IN_DATA_W-1:0]       s_axis_tdata,    // [15:0] sample_i, [31:16] sample_q
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [afps_pkg::OUT_DATA_W-1:0]      m_axis_tdata,    // [5:0] bin_index, [21:6] power_db
  output logic                                 m_axis_tlast     // last_bin
);
  import afps_pkg::*;

  typedef enum logic [23:0] {
    ST_IDLE    = 24'd1 << 0,
    ST_WIN0    = 24'd1 << 1,
    ST_WIN1    = 24'd1 << 2,
    ST_WIN2    = 24'd1 << 3,
    ST_BF_RD   = 24'd1 << 4,
    ST_BF_M0   = 24'd1 << 5,
    ST_BF_M1   = 24'd1 << 6,
    ST_BF_M2   = 24'd1 << 7,
    ST_BF_M3   = 24'd1 << 8,
    ST_BF_WA   = 24'd1 << 9,
    ST_BF_WC   = 24'd1 << 10,
    ST_PW_RD   = 24'd1 << 11,
    ST_PW_M0   = 24'd1 << 12,
    ST_PW_M1   = 24'd1 << 13,
    ST_PW_WR   = 24'd1 << 14,
    ST_OUT_RD  = 24'd1 << 15,
    ST_DIV_GO  = 24'd1 << 16,
    ST_DIV     = 24'd1 << 17,
    ST_NORM    = 24'd1 << 18,
    ST_SQ_M    = 24'd1 << 19,
    ST_SQ_CHK  = 24'd1 << 20,
    ST_DB_M    = 24'd1 << 21,
    ST_DB_RND  = 24'd1 << 22,
    ST_OUT_PUT = 24'd1 << 23
  } state_e;

  state_e state_q, state_d;

  // control registers
  logic [LOG_N-1:0]   fill_q, idx_q;
  logic [STG_W-1:0]   stage_q;
  logic [LOG_N-2:0]   bf_q;
  logic [FD_W-1:0]    frames_done_q;
  logic [CNT_W-1:0]   avg_cfg_q;
  logic               m_valid_q;
  logic [FFT_N-1:0]   acc_vld_q;
  logic               acc_hit_q;
  logic [4:0]         it_q;
  logic [LOG_N-1:0]   z_q;

  // datapath registers
  logic signed [SMP_W-1:0]  smp_i_q, smp_q_q;
  logic signed [XW-1:0]     xw_q, tr_q, ti_q;
  logic signed [COEF_W-1:0] wc_q, ws_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [NORM_W-1:0]        norm_q;
  logic [M_W-1:0]           m_q;
  logic [FRAC_W-1:0]        frac_q;
  logic signed [DB_W-1:0]   db_q;
  logic [CNT_W-1:0]         frames_q;
  logic [OUT_DATA_W-1:0]    m_data_q;
  logic                     m_last_q;

  logic s_acc, out_load;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_OUT_PUT) && (!m_valid_q || m_axis_tready);

  // butterfly addressing: j inside the group, group base, twiddle index
  logic [LOG_N-2:0] jmask, bf_j;
  logic [LOG_N-1:0] bf_a, bf_c, tw_idx;
  assign jmask  = ((LOG_N-1)'(1) << stage_q) - (LOG_N-1)'(1);
  assign bf_j   = bf_q & jmask;
  assign bf_a   = {bf_q & ~jmask, 1'b0} | LOG_N'(bf_j);
  assign bf_c   = bf_a | (LOG_N'(1) << stage_q);
  assign tw_idx = {1'b0, bf_j} << (STG_W'(LOG_N - 1) - stage_q);

  // fft work memory, {re, im}
  logic [2*XW-1:0]  work_mem [FFT_N];
  logic [2*XW-1:0]  rd0_q, rd1_q, work_wd;
  logic [LOG_N-1:0] work_wa, rd0_a, rd1_a;
  logic             work_we, work_re;

  always_ff @(posedge clk_i) begin
    if (work_we) work_mem[work_wa] <= work_wd;
    if (work_re) begin
      rd0_q <= work_mem[rd0_a];
      rd1_q <= work_mem[rd1_a];
    end
  end

  logic signed [XW-1:0] xr_a, xi_a, xr_c, xi_c, ti_c;
  assign xr_a = rd0_q[2*XW-1:XW];
  assign xi_a = rd0_q[XW-1:0];
  assign xr_c = rd1_q[2*XW-1:XW];
  assign xi_c = rd1_q[XW-1:0];

  // per-bin power accumulators, valid bit clear means zero
  logic [ACC_W-1:0] acc_mem [FFT_N];
  logic [ACC_W-1:0] acc_rd_q, acc_val, acc_wd;
  logic [LOG_N-1:0] acc_ra;
  logic             acc_re, acc_we;

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[idx_q] <= acc_wd;
    if (acc_re) acc_rd_q <= acc_mem[acc_ra];
  end

  assign acc_val = acc_hit_q ? acc_rd_q : '0;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  afps_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // serial divider for the mean
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_quo;

  afps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({acc_val, 8'd0}),
    .divisor_i  (frames_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // log2 assembly: exponent from the shift count, fraction from squarings
  logic [LOG_N-1:0]       e_val;
  logic signed [6:0]      e_off;
  logic signed [LG_W-1:0] lg;
  assign e_val = LOG_N'(NORM_W - 1) - z_q;
  assign e_off = $signed({1'b0, e_val}) - 7'sd47;
  assign lg    = $signed({e_off, frac_q});

  logic [PROD_W-1:0] sq;
  assign sq = mul_p >> 30;

  // frame completion
  logic [CNT_W-1:0] cnt, frames_nx;
  logic             spec_done;
  always_comb begin
    cnt = avg_cfg_q;
    if (avg_cfg_q == '0) cnt = CNT_W'(1);
    else if (avg_cfg_q > CNT_W'(MAX_AVG)) cnt = CNT_W'(MAX_AVG);
  end
  assign frames_nx = {1'b0, frames_done_q} + CNT_W'(1);
  assign spec_done = frames_nx >= cnt;

  // power of one bin, added with saturation
  logic signed [PROD_W-1:0] pw;
  logic [ACC_W:0]           acc_sum;
  assign pw      = rnd_sh(prod_q + mul_p, PW_SH);
  assign acc_sum = {1'b0, acc_val} + (ACC_W+1)'(pw);
  assign acc_wd  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

  assign ti_c = XW'(rnd_sh(prod_q - mul_p, 15));

  logic signed [PROD_W-1:0] db_r;
  assign db_r = rnd_sh(mul_p, 40);

  // memory ports and multiplier operands
  always_comb begin
    work_we   = 1'b0;
    work_wa   = bf_a;
    work_wd   = {xr_a + tr_q, xi_a + ti_c};
    work_re   = 1'b0;
    rd0_a     = bf_a;
    rd1_a     = bf_c;
    acc_re    = 1'b0;
    acc_ra    = idx_q;
    acc_we    = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_WIN0: begin
        mul_a = MUL_W'(smp_i_q);
        mul_b = MUL_W'(WIN_TAB[fill_q]);
      end
      ST_WIN1: begin
        mul_a = MUL_W'(smp_q_q);
        mul_b = MUL_W'(WIN_TAB[fill_q]);
      end
      ST_WIN2: begin
        work_we = 1'b1;
        work_wa = bit_rev(fill_q);
        work_wd = {xw_q, XW'(rnd_sh(mul_p, 15))};
      end
      ST_BF_RD: work_re = 1'b1;
      ST_BF_M0: begin
        mul_a = MUL_W'(xr_c);
        mul_b = MUL_W'(wc_q);
      end
      ST_BF_M1: begin
        mul_a = MUL_W'(xi_c);
        mul_b = MUL_W'(ws_q);
      end
      ST_BF_M2: begin
        mul_a = MUL_W'(xi_c);
        mul_b = MUL_W'(wc_q);
      end
      ST_BF_M3: begin
        mul_a = MUL_W'(xr_c);
        mul_b = MUL_W'(ws_q);
      end
      ST_BF_WA: work_we = 1'b1;
      ST_BF_WC: begin
        work_we = 1'b1;
        work_wa = bf_c;
        work_wd = {xr_a - tr_q, xi_a - ti_q};
      end
      ST_PW_RD: begin
        work_re = 1'b1;
        rd0_a   = idx_q;
        rd1_a   = idx_q;
        acc_re  = 1'b1;
      end
      ST_PW_M0: begin
        mul_a = MUL_W'(xr_a);
        mul_b = MUL_W'(xr_a);
      end
      ST_PW_M1: begin
        mul_a = MUL_W'(xi_a);
        mul_b = MUL_W'(xi_a);
      end
      ST_PW_WR: acc_we = 1'b1;
      ST_OUT_RD: begin
        acc_re = 1'b1;
        acc_ra = idx_q ^ LOG_N'(FFT_N / 2);
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_SQ_M: begin
        mul_a = MUL_W'(m_q);
        mul_b = MUL_W'(m_q);
      end
      ST_DB_M: begin
        mul_a = MUL_W'(lg);
        mul_b = DB_K;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_acc) state_d = ST_WIN0;
      ST_WIN0:   state_d = ST_WIN1;
      ST_WIN1:   state_d = ST_WIN2;
      ST_WIN2:   state_d = (fill_q == LOG_N'(FFT_N - 1)) ? ST_BF_RD : ST_IDLE;
      ST_BF_RD:  state_d = ST_BF_M0;
      ST_BF_M0:  state_d = ST_BF_M1;
      ST_BF_M1:  state_d = ST_BF_M2;
      ST_BF_M2:  state_d = ST_BF_M3;
      ST_BF_M3:  state_d = ST_BF_WA;
      ST_BF_WA:  state_d = ST_BF_WC;
      ST_BF_WC: begin
        if (bf_q == '1 && stage_q == STG_W'(LOG_N - 1)) state_d = ST_PW_RD;
        else state_d = ST_BF_RD;
      end
      ST_PW_RD:  state_d = ST_PW_M0;
      ST_PW_M0:  state_d = ST_PW_M1;
      ST_PW_M1:  state_d = ST_PW_WR;
      ST_PW_WR: begin
        if (idx_q != LOG_N'(FFT_N - 1)) state_d = ST_PW_RD;
        else state_d = spec_done ? ST_OUT_RD : ST_IDLE;
      end
      ST_OUT_RD: state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_NORM;
      ST_NORM:   if (norm_q[NORM_W-1]) state_d = ST_SQ_M;
      ST_SQ_M:   state_d = ST_SQ_CHK;
      ST_SQ_CHK: state_d = (it_q == 5'(FRAC_W - 1)) ? ST_DB_M : ST_SQ_M;
      ST_DB_M:   state_d = ST_DB_RND;
      ST_DB_RND: state_d = ST_OUT_PUT;
      ST_OUT_PUT: begin
        if (out_load) state_d = (idx_q == LOG_N'(FFT_N - 1)) ? ST_IDLE : ST_OUT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fill_q        <= '0;
      idx_q         <= '0;
      stage_q       <= '0;
      bf_q          <= '0;
      frames_done_q <= '0;
      avg_cfg_q     <= CNT_W'(1);
      m_valid_q     <= 1'b0;
      acc_vld_q     <= '0;
      acc_hit_q     <= 1'b0;
      it_q          <= '0;
      z_q           <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) avg_cfg_q <= cfg_wdata_i;
      if (acc_re) acc_hit_q <= acc_vld_q[acc_ra];

      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;

      case (state_q)
        ST_WIN2: fill_q <= fill_q + 1'b1;
        ST_BF_WC: begin
          bf_q <= bf_q + 1'b1;
          if (bf_q == '1) begin
            if (stage_q == STG_W'(LOG_N - 1)) begin
              stage_q <= '0;
              idx_q   <= '0;
            end else begin
              stage_q <= stage_q + 1'b1;
            end
          end
        end
        ST_PW_WR: begin
          acc_vld_q[idx_q] <= 1'b1;
          idx_q <= idx_q + 1'b1;
          if (idx_q == LOG_N'(FFT_N - 1) && !spec_done) frames_done_q <= frames_nx[FD_W-1:0];
        end
        ST_DIV: z_q <= '0;
        ST_NORM: begin
          if (!norm_q[NORM_W-1]) z_q <= z_q + 1'b1;
          it_q <= '0;
        end
        ST_SQ_CHK: it_q <= it_q + 1'b1;
        ST_OUT_PUT: begin
          if (out_load) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == LOG_N'(FFT_N - 1)) begin
              acc_vld_q     <= '0;
              frames_done_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          smp_i_q <= s_axis_tdata[SMP_W-1:0];
          smp_q_q <= s_axis_tdata[IN_DATA_W-1:SMP_W];
        end
      end
      ST_WIN1:  xw_q <= XW'(rnd_sh(mul_p, 15));
      ST_BF_RD: begin
        wc_q <= TW_COS[tw_idx];
        ws_q <= TW_SIN[tw_idx];
      end
      ST_BF_M1, ST_BF_M3, ST_PW_M1: prod_q <= mul_p;
      ST_BF_M2: tr_q <= XW'(rnd_sh(prod_q + mul_p, 15));
      ST_BF_WA: ti_q <= ti_c;
      ST_PW_WR: frames_q <= frames_nx;
      ST_DIV:   if (div_done) norm_q <= NORM_W'(div_quo) + EPS_Q47;
      ST_NORM: begin
        if (!norm_q[NORM_W-1]) begin
          norm_q <= norm_q << 1;
        end else begin
          m_q    <= norm_q[NORM_W-1 -: M_W];
          frac_q <= '0;
        end
      end
      ST_SQ_CHK: begin
        if (sq[31]) begin
          m_q    <= sq[M_W:1];
          frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
        end else begin
          m_q    <= sq[M_W-1:0];
          frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
        end
      end
      ST_DB_RND: begin
        if (!db_r[PROD_W-1] && db_r != '0) db_q <= '0;
        else if (db_r < PROD_W'(DB_MIN)) db_q <= DB_W'(DB_MIN);
        else db_q <= db_r[DB_W-1:0];
      end
      ST_OUT_PUT: begin
        if (out_load) begin
          m_data_q <= OUT_DATA_W'({db_q, idx_q});
          m_last_q <= (idx_q == LOG_N'(FFT_N - 1));
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // the last bin of a spectrum carries the top index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[LOG_N-1:0] == LOG_N'(FFT_N - 1))
    else $error("last word without top bin index");

  // emitting the last bin empties every accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && idx_q == LOG_N'(FFT_N - 1) |=> acc_vld_q == '0)
    else $error("accumulators not cleared after spectrum");

  // db result stays inside the saturation range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[LOG_N+DB_W-1:LOG_N]) <= 0 &&
                       $signed(m_axis_tdata[LOG_N+DB_W-1:LOG_N]) >= DB_MIN))
    else $error("db value out of range");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider done outside its wait state");

  // squaring loop always works on a normalized mantissa
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQ_CHK |-> m_q[M_W-1])
    else $error("mantissa not normalized");

endmodule

FILE: verif/averaged_fft_power_spectrum_test.sv
// self-checking testbench for the averaged fft power spectrum block
`timescale 1ns / 100ps

module averaged_fft_power_spectrum_test;
  import afps_pkg::*;

  localparam int HALF_N = FFT_N / 2;

  // predicted output word
  typedef struct packed {
    logic [LOG_N-1:0]       bin;
    logic signed [DB_W-1:0] db;
    logic                   last;
  } bin_word_t;

  // directed sample shapes
  typedef enum logic [2:0] {
    FR_ZERO, FR_DC_EXTREME, FR_ALTERNATE, FR_IMPULSE, FR_TONE
  } frame_shape_e;

  // one row: a shape held for a run of samples, rows together fill one frame
  typedef struct {
    frame_shape_e shape;
    int           len;
  } frame_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CNT_W-1:0]        cfg_wdata_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    m_axis_tlast;

  averaged_fft_power_spectrum DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predictor state
  longint          hann_q15 [FFT_N];
  longint          twid_cos [FFT_N];
  longint          twid_sin [FFT_N];
  longint          frame_re [FFT_N];
  longint          frame_im [FFT_N];
  longint unsigned bin_power [FFT_N];
  int              fill_pos;
  int              frames_summed;
  int              avg_setting;
  bin_word_t       spectrum_q [$];

  int  errors;
  int  rx_mode;   // 0: steady, 1: random stalls
  int  tx_mode;
  int  rx_hold = 0;

  frame_row_t directed_rows [5] = '{
    '{FR_ZERO,        8},
    '{FR_DC_EXTREME, 16},
    '{FR_ALTERNATE,  16},
    '{FR_IMPULSE,     8},
    '{FR_TONE,       16}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // round half away from zero
  function automatic longint round_away(longint v, int s);
    longint h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  // q30 cos / sin of 2*pi*p/d by truncated series over one quadrant
  function automatic void quadrant_trig(longint p, longint d, output longint c,
                                        output longint s);
    longint cden [6] = '{132, 90, 56, 30, 12, 2};
    longint sden [6] = '{156, 110, 72, 42, 20, 6};
    longint q, quad, r, x, x2, tc, ts, cv, sv;
    q    = 4 * (p % d);
    quad = q / d;
    r    = q % d;
    x    = (r * 64'sd1686629713) / d;
    x2   = (x * x) >>> 30;
    tc   = 64'sd1 <<< 30;
    ts   = 64'sd1 <<< 30;
    for (int k = 0; k < 5; k++) tc = (64'sd1 <<< 30) - ((x2 * tc) >>> 30) / cden[k];
    cv = (64'sd1 <<< 30) - ((x2 * tc) >>> 30) / cden[5];
    for (int k = 0; k < 6; k++) ts = (64'sd1 <<< 30) - ((x2 * ts) >>> 30) / sden[k];
    sv = (x * ts) >>> 30;
    case (quad & 3)
      0: begin c = cv;  s = sv;  end
      1: begin c = -sv; s = cv;  end
      2: begin c = -cv; s = -sv; end
      default: begin c = sv; s = -cv; end
    endcase
  endfunction

  // mean power to db*256 via a squaring log2
  function automatic logic signed [DB_W-1:0] mean_db(longint unsigned acc, int n);
    longint unsigned v, m;
    longint fr, lg, r;
    int e;
    v  = ((acc << 8) / longint'(n)) + EPS_Q47;
    e  = 0;
    fr = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
    for (int i = 0; i < 24; i++) begin
      m  = (m * m) >> 30;
      fr = fr <<< 1;
      if (m >= (64'd1 << 31)) begin
        m  = m >> 1;
        fr = fr | 1;
      end
    end
    lg = longint'(e - 47) * (64'sd1 <<< 24) + fr;
    r  = round_away(lg * longint'(DB_K), 40);
    if (r > 0) r = 0;
    if (r < DB_MIN) r = DB_MIN;
    return DB_W'(r);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // window, fft and power sum of the completed frame
  task automatic sum_frame_power();
    longint xr [FFT_N], xi [FFT_N];
    longint tr, ti, wc, ws, mag, p;
    int rev, hlf, stp, a, c;
    for (int n = 0; n < FFT_N; n++) begin
      rev = 0;
      for (int b = 0; b < LOG_N; b++) rev |= ((n >> b) & 1) << (LOG_N - 1 - b);
      xr[rev] = round_away(frame_re[n] * hann_q15[n], 15);
      xi[rev] = round_away(frame_im[n] * hann_q15[n], 15);
    end
    for (int len = 2; len <= FFT_N; len = len * 2) begin
      hlf = len / 2;
      stp = FFT_N / len;
      for (int j = 0; j < hlf; j++) begin
        wc = twid_cos[(j * stp) % FFT_N];
        ws = twid_sin[(j * stp) % FFT_N];
        for (int base = 0; base + len <= FFT_N; base += len) begin
          a = base + j;
          c = a + hlf;
          tr = round_away(xr[c] * wc + xi[c] * ws, 15);
          ti = round_away(xi[c] * wc - xr[c] * ws, 15);
          xr[c] = xr[a] - tr;
          xi[c] = xi[a] - ti;
          xr[a] = xr[a] + tr;
          xi[a] = xi[a] + ti;
        end
      end
    end
    for (int n = 0; n < FFT_N; n++) begin
      mag = xr[n] * xr[n] + xi[n] * xi[n];
      p   = (PW_SH > 0) ? round_away(mag, PW_SH) : (mag <<< (-PW_SH));
      bin_power[n] = bin_power[n] + longint'(p);
      if (bin_power[n] > ((64'd1 << ACC_W) - 1)) bin_power[n] = (64'd1 << ACC_W) - 1;
    end
  endtask

  // take one accepted sample into the predictor, queue any spectrum it completes
  task automatic predict_sample(logic signed [SMP_W-1:0] si, logic signed [SMP_W-1:0] sq);
    int need, frames;
    bin_word_t w;
    frame_re[fill_pos] = si;
    frame_im[fill_pos] = sq;
    fill_pos++;
    if (fill_pos < FFT_N) return;
    fill_pos = 0;
    sum_frame_power();
    need = (avg_setting == 0) ? 1 : (avg_setting > MAX_AVG ? MAX_AVG : avg_setting);
    frames = frames_summed + 1;
    if (frames < need) begin
      frames_summed = frames;
      return;
    end
    for (int k = 0; k < FFT_N; k++) begin
      w.bin  = LOG_N'(k);
      w.db   = mean_db(bin_power[(k + HALF_N) % FFT_N], frames);
      w.last = (k == FFT_N - 1);
      spectrum_q.push_back(w);
    end
    foreach (bin_power[n]) bin_power[n] = 0;
    frames_summed = 0;
  endtask

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  task automatic send_sample(logic signed [SMP_W-1:0] si, logic signed [SMP_W-1:0] sq);
    int gap;
    gap = (tx_mode != 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sq, si};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sample(si, sq);
  endtask

  task automatic write_avg(int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    avg_setting = value;
  endtask

  // wait for every expected word, then let trailing work finish
  task automatic drain(int extra);
    s_axis_tvalid <= 1'b0;
    while (spectrum_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // random frame, amplitude scaled per frame so the db range is covered
  task automatic random_frame();
    int sh;
    logic signed [SMP_W-1:0] si, sq;
    sh = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    for (int n = 0; n < FFT_N; n++) begin
      si = $signed(SMP_W'($urandom)) >>> sh;
      sq = $signed(SMP_W'($urandom)) >>> sh;
      send_sample(si, sq);
    end
  endtask

  task automatic directed_row(frame_row_t row);
    logic signed [SMP_W-1:0] si, sq;
    for (int n = 0; n < row.len; n++) begin
      case (row.shape)
        FR_ZERO:       begin si = 0; sq = 0; end
        FR_DC_EXTREME: begin si = 16'sh7fff; sq = 16'sh8000; end
        FR_ALTERNATE:  begin
          si = n[0] ? 16'sh8000 : 16'sh7fff;
          sq = n[0] ? 16'sh7fff : 16'sh8000;
        end
        FR_IMPULSE:    begin
          si = (n == 0) ? 16'sh8000 : 16'sh0000;
          sq = (n == 0) ? 16'sh8000 : 16'sh0000;
        end
        default:       begin
          // tone at bin 59 from the twiddle table, half scale
          si = SMP_W'(twid_cos[(5 * n) % FFT_N] >>> 1);
          sq = SMP_W'(-(twid_sin[(5 * n) % FFT_N] >>> 1));
        end
      endcase
      send_sample(si, sq);
    end
  endtask

  // check each accepted output word against the oldest prediction
  always @(posedge clk_i) begin
    bin_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (spectrum_q.size() == 0) begin
        report_mismatch("output word with nothing expected");
      end else begin
        w = spectrum_q.pop_front();
        if (m_axis_tdata[LOG_N-1:0] !== w.bin)
          report_mismatch($sformatf("bin %0d, expected %0d", m_axis_tdata[LOG_N-1:0], w.bin));
        if ($signed(m_axis_tdata[LOG_N +: DB_W]) !== w.db)
          report_mismatch($sformatf("bin %0d power %0d, expected %0d", w.bin,
                                    $signed(m_axis_tdata[LOG_N +: DB_W]), w.db));
        if (m_axis_tlast !== w.last)
          report_mismatch($sformatf("bin %0d last %b, expected %b", w.bin,
                                    m_axis_tlast, w.last));
      end
    end
    // ready stays low for the whole chosen gap
    if (rx_hold == 0) rx_hold = (rx_mode != 0) ? pick_gap() : 0;
    else rx_hold--;
    m_axis_tready <= (rx_hold == 0);
  end

  initial begin
    errors        = 0;
    rx_mode       = 0;
    tx_mode       = 0;
    fill_pos      = 0;
    frames_summed = 0;
    avg_setting   = 1;
    foreach (bin_power[n]) bin_power[n] = 0;
    for (int n = 0; n < FFT_N; n++) begin
      longint c, s;
      quadrant_trig(n, FFT_N - 1, c, s);
      hann_q15[n] = round_away((64'sd1 <<< 30) - c, 16);
      quadrant_trig(n, FFT_N, c, s);
      twid_cos[n] = round_away(c, 15);
      twid_sin[n] = round_away(s, 15);
    end
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frame built from the row table, summed toward a count of three
    write_avg(3);
    foreach (directed_rows[r]) directed_row(directed_rows[r]);
    drain(2500);

    // count lowered to zero while averaging: acts as one, mean over two frames
    rx_mode = 1;
    tx_mode = 1;
    write_avg(0);
    random_frame();
    drain(400);

    if (spectrum_q.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", spectrum_q.size()));
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/afps_pkg.sv
rtl/afps_mul.sv
rtl/afps_div.sv
rtl/averaged_fft_power_spectrum.sv
verif/averaged_fft_power_spectrum_test.sv
